>>> sv/lnpks_pkg.sv
// Shared types and constants for the last-note-priority key stack.
`default_nettype none

package lnpks_pkg;

    localparam int KEY_COUNT_DEF = 64;

    localparam int MODE_W    = 2;
    localparam int KEY_IN_W  = 7;
    localparam int TOP_W     = 6;
    localparam int HCOUNT_W  = 7;

    typedef enum logic [MODE_W-1:0] {
        MODE_PRESS       = 2'd0,
        MODE_RELEASE     = 2'd1,
        MODE_RELEASE_ALL = 2'd2,
        MODE_SOLO        = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SHIFT,
        ST_OUT
    } t_state;

    // token and "target already passed" flag walking up the cell chain
    typedef struct packed {
        logic tok;
        logic found;
    } t_link;

endpackage

`default_nettype wire

>>> sv/lnpks_cell.sv
// One slot of the held-key list; shifts down when a release token passes at or above the released key's slot.
`default_nettype none

module lnpks_cell #(
    parameter int IDX = 0,
    parameter int KW  = 6,
    parameter int CW  = 7
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_load,
    input  wire  [KW-1:0]         i_key,
    input  wire  [CW-1:0]         i_count,
    input  wire  [KW-1:0]         i_nxt_key,
    input  lnpks_pkg::t_link      i_link,
    output logic [KW-1:0]         o_key,
    output lnpks_pkg::t_link      o_link
);
    import lnpks_pkg::*;

    localparam logic [CW-1:0] IDX_C = CW'(IDX);

    logic [KW-1:0] r_key;
    t_link         r_link;
    logic          w_hit;

    // this slot or one below it held the released key: take the neighbor's word
    assign w_hit = i_link.tok &&
                   (i_link.found || ((r_key == i_key) && (IDX_C < i_count)));

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_key <= i_key;
        end else if (w_hit) begin
            r_key <= i_nxt_key;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link <= '0;
        end else begin
            r_link.tok   <= i_link.tok;
            r_link.found <= w_hit;
        end
    end

    assign o_key  = r_key;
    assign o_link = r_link;

endmodule

`default_nettype wire

>>> sv/last_note_priority_key_stack.sv
// Top level: last-note-priority key stack built from a chain of list cells.
//
//  channel   | handshake          | words
//  ----------+--------------------+--------------------------------------
//  event in  | start / busy       | i_mode, i_key_index
//  result    | o_valid (strobe)   | o_top_key, o_key_held, o_held_count
//
// Press, release-all, ignored events: accepted in ST_IDLE; the result strobe
// follows in the next cycle, with busy high. Release of a held key: a token walks
// the cell chain one cell per cycle, and busy stays high until it leaves the last cell.
// Synchronous active-low reset empties the list; list cell contents are not
// reset. The result strobe lasts one cycle; the receiver cannot stall it.
`default_nettype none

module last_note_priority_key_stack #(
    parameter int KEY_COUNT = lnpks_pkg::KEY_COUNT_DEF
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             start,
    output logic                            busy,
    input  wire  [lnpks_pkg::MODE_W-1:0]    i_mode,
    input  wire  [lnpks_pkg::KEY_IN_W-1:0]  i_key_index,
    output logic                            o_valid,
    output logic [lnpks_pkg::TOP_W-1:0]     o_top_key,
    output logic                            o_key_held,
    output logic [lnpks_pkg::HCOUNT_W-1:0]  o_held_count
);
    import lnpks_pkg::*;

    localparam int KW = (KEY_COUNT > 2) ? $clog2(KEY_COUNT) : 1;
    localparam int CW = $clog2(KEY_COUNT + 1);

    t_state              r_state, n_state;
    logic [CW-1:0]       r_count;
    logic [KEY_COUNT-1:0] r_held;
    logic [KW-1:0]       r_k;
    logic                r_start;

    logic                w_accept;
    logic                w_in_range;
    logic [KW-1:0]       w_k;
    logic                w_k_held;
    logic                w_do_load;
    logic [CW-1:0]       w_load_idx;
    logic                w_do_release;
    logic                w_clear_all;
    logic                w_shift_done;

    logic [KW-1:0]       w_key  [KEY_COUNT];
    t_link               w_link [KEY_COUNT+1];
    logic [KW-1:0]       w_top_idx;
    logic [HCOUNT_W-1:0] w_top_wide;

    assign w_accept   = start && !busy;
    assign w_in_range = {1'b0, i_key_index} < (KEY_IN_W + 1)'(KEY_COUNT);
    assign w_k        = i_key_index[KW-1:0];
    assign w_k_held   = w_in_range && r_held[w_k];
    assign w_shift_done = w_link[KEY_COUNT].tok;

    // event decode
    always_comb begin
        w_do_load    = 1'b0;
        w_load_idx   = r_count;
        w_do_release = 1'b0;
        w_clear_all  = 1'b0;
        unique case (t_mode'(i_mode))
            MODE_PRESS: begin
                w_do_load = w_in_range && !w_k_held && (r_count < CW'(KEY_COUNT));
            end
            MODE_RELEASE: begin
                w_do_release = w_k_held && (r_count != '0);
            end
            MODE_RELEASE_ALL: begin
                w_clear_all = 1'b1;
            end
            MODE_SOLO: begin
                w_clear_all = 1'b1;
                w_do_load   = w_in_range;
                w_load_idx  = '0;
            end
            default: begin
                w_clear_all = 1'b0;
            end
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_state = w_do_release ? ST_SHIFT : ST_OUT;
                end
            end
            ST_SHIFT: begin
                if (w_shift_done) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT:  n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // FSM outputs
    always_comb begin
        busy    = 1'b1;
        o_valid = 1'b0;
        unique case (r_state)
            ST_IDLE:  busy = 1'b0;
            ST_SHIFT: busy = 1'b1;
            ST_OUT:   o_valid = 1'b1;
            default:  busy = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_held  <= '0;
            r_start <= 1'b0;
        end else begin
            r_state <= n_state;
            r_start <= w_accept && w_do_release;
            if (w_accept) begin
                if (w_clear_all) begin
                    r_held  <= '0;
                    r_count <= '0;
                end
                if (w_do_load) begin
                    r_held[w_k] <= 1'b1;
                    r_count     <= w_load_idx + CW'(1);
                end
            end else if (r_state == ST_SHIFT && w_shift_done) begin
                r_held[r_k] <= 1'b0;
                r_count     <= r_count - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_k <= w_k;
        end
    end

    assign w_link[0] = '{tok: r_start, found: 1'b0};

    for (genvar gi = 0; gi < KEY_COUNT; gi++) begin : g_cell
        logic [KW-1:0] w_nxt;
        if (gi == KEY_COUNT - 1) begin : g_last
            assign w_nxt = '0;
        end else begin : g_mid
            assign w_nxt = w_key[gi+1];
        end

        lnpks_cell #(
            .IDX (gi),
            .KW  (KW),
            .CW  (CW)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_load    (w_accept && w_do_load && (w_load_idx == CW'(gi))),
            .i_key     (w_accept ? w_k : r_k),
            .i_count   (r_count),
            .i_nxt_key (w_nxt),
            .i_link    (w_link[gi]),
            .o_key     (w_key[gi]),
            .o_link    (w_link[gi+1])
        );
    end

    // newest held key sits in the slot just below the count
    assign w_top_idx  = KW'(r_count - CW'(1));
    assign w_top_wide = (r_count != '0) ? HCOUNT_W'(w_key[w_top_idx]) : '0;

    assign o_top_key    = w_top_wide[TOP_W-1:0];
    assign o_key_held   = (r_count != '0);
    assign o_held_count = HCOUNT_W'(r_count);

    a_strobe_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted event did not raise busy");

    a_count_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_held) == int'(r_count))
        else $error("held flags disagree with list count");

    a_shift_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SHIFT) |-> (r_count != '0))
        else $error("release walk on empty list");

endmodule

`default_nettype wire

>>> sim/tb_last_note_priority_key_stack.sv
// Self-checking testbench for the last-note-priority key stack: event words in, stack words checked.

module tb_last_note_priority_key_stack;
    timeunit 1ns;
    timeprecision 1ps;

    import lnpks_pkg::*;

    localparam int NKEYS       = KEY_COUNT_DEF;
    localparam int IDLE_LIMIT  = 2000;
    localparam int TAIL_CYCLES = NKEYS + 8;

    typedef struct packed {
        logic [TOP_W-1:0]    top_key;
        logic                key_held;
        logic [HCOUNT_W-1:0] held_count;
    } t_stack_word;

    logic                i_clk;
    logic                i_rst_n;
    logic                start;
    logic                busy;
    t_mode               mode_drv;
    logic [KEY_IN_W-1:0] key_drv;
    logic                o_valid;
    logic [TOP_W-1:0]    o_top_key;
    logic                o_key_held;
    logic [HCOUNT_W-1:0] o_held_count;

    // predicted stack: keys in press order, 1-based position per key
    logic [TOP_W-1:0]    stack_keys [NKEYS];
    logic [HCOUNT_W-1:0] stack_pos  [NKEYS];
    int                  stack_depth;
    int                  peak_depth;

    t_stack_word expected_words [$];
    int burst_left      = 0;
    int events_sent     = 0;
    int results_checked = 0;
    int mismatches      = 0;
    int idle_cycles     = 0;

    last_note_priority_key_stack #(
        .KEY_COUNT(NKEYS)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_mode      (mode_drv),
        .i_key_index (key_drv),
        .o_valid     (o_valid),
        .o_top_key   (o_top_key),
        .o_key_held  (o_key_held),
        .o_held_count(o_held_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic void press_into_stack(int k);
        if (k >= NKEYS || stack_pos[k] != 0 || stack_depth >= NKEYS)
            return;
        stack_keys[stack_depth] = k[TOP_W-1:0];
        stack_depth++;
        stack_pos[k] = stack_depth[HCOUNT_W-1:0];
    endfunction

    function automatic void release_from_stack(int k);
        int pos;
        if (k >= NKEYS || stack_pos[k] == 0 || stack_depth == 0)
            return;
        pos = int'(stack_pos[k]) - 1;
        if (pos >= stack_depth)
            pos = stack_depth - 1;
        // close the gap: everything above slides down one place
        for (int i = pos + 1; i < stack_depth; i++) begin
            stack_keys[i-1] = stack_keys[i];
            stack_pos[stack_keys[i]] = i[HCOUNT_W-1:0];
        end
        stack_pos[k] = '0;
        stack_depth--;
    endfunction

    function automatic void clear_stack();
        for (int i = 0; i < stack_depth; i++)
            stack_pos[stack_keys[i]] = '0;
        stack_depth = 0;
    endfunction

    function automatic t_stack_word predict_stack(t_mode m, logic [KEY_IN_W-1:0] k);
        t_stack_word w;
        case (m)
            MODE_PRESS:       press_into_stack(int'(k));
            MODE_RELEASE:     release_from_stack(int'(k));
            MODE_RELEASE_ALL: clear_stack();
            default: begin
                clear_stack();
                press_into_stack(int'(k));
            end
        endcase
        w.top_key    = (stack_depth > 0) ? stack_keys[stack_depth-1] : '0;
        w.key_held   = (stack_depth > 0);
        w.held_count = stack_depth[HCOUNT_W-1:0];
        if (stack_depth > peak_depth)
            peak_depth = stack_depth;
        return w;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        mismatches++;
        if (mismatches <= 40)
            $display("mismatch at %0t ns: %s got %0d expected %0d (result %0d)",
                     $time, what, got, want, results_checked);
    endtask

    // one event word; sender idles between bursts of random length
    task automatic send_event(t_mode m, logic [KEY_IN_W-1:0] k);
        if (burst_left == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 150)
                                                      : $urandom_range(1, 16);
        end
        start    <= 1'b1;
        mode_drv <= m;
        key_drv  <= k;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        expected_words.push_back(predict_stack(m, k));
        events_sent++;
        burst_left--;
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        burst_left = 0;
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    task automatic test_empty_events();
        send_event(MODE_RELEASE, 7'd5);
        send_event(MODE_RELEASE_ALL, 7'd0);
        send_event(MODE_PRESS, 7'd64);
        send_event(MODE_PRESS, 7'd127);
        send_event(MODE_SOLO, 7'd127);
    endtask

    task automatic test_press_release_order();
        send_event(MODE_PRESS, 7'd0);
        send_event(MODE_PRESS, 7'd63);
        send_event(MODE_PRESS, 7'd31);
        send_event(MODE_PRESS, 7'd63);      // already held, order unchanged
        send_event(MODE_RELEASE, 7'd10);    // not held
        send_event(MODE_RELEASE, 7'd100);   // out of range
        send_event(MODE_RELEASE, 7'd0);     // bottom of the list
        send_event(MODE_RELEASE, 7'd31);    // top of the list
        send_event(MODE_RELEASE, 7'd63);
        send_event(MODE_RELEASE, 7'd63);
    endtask

    task automatic test_solo_and_release_all();
        send_event(MODE_PRESS, 7'd5);
        send_event(MODE_PRESS, 7'd6);
        send_event(MODE_SOLO, 7'd40);
        send_event(MODE_SOLO, 7'd99);       // clears, press part ignored
        send_event(MODE_PRESS, 7'd1);
        send_event(MODE_PRESS, 7'd2);
        send_event(MODE_RELEASE_ALL, 7'd127);
        send_event(MODE_SOLO, 7'd0);
    endtask

    task automatic test_random_play(int n_events);
        int                  roll;
        t_mode               m;
        logic [KEY_IN_W-1:0] k;
        for (int i = 0; i < n_events; i++) begin
            roll = $urandom_range(0, 99);
            k    = KEY_IN_W'($urandom_range(0, NKEYS - 1));
            if (roll < 47) begin
                m = MODE_PRESS;
                // small key pool so repeat presses happen
                if ($urandom_range(0, 2) == 0)
                    k = KEY_IN_W'($urandom_range(0, 11));
            end else if (roll < 88) begin
                m = MODE_RELEASE;
                if (stack_depth > 0 && $urandom_range(0, 4) != 0)
                    k = KEY_IN_W'(stack_keys[$urandom_range(0, stack_depth - 1)]);
            end else if (roll < 90) begin
                m = MODE_RELEASE_ALL;
            end else if (roll < 92) begin
                m = MODE_SOLO;
            end else begin
                m = t_mode'($urandom_range(0, 3));
                k = KEY_IN_W'($urandom_range(NKEYS, 127));
            end
            send_event(m, k);
        end
    endtask

    // press every key in random order, then release them in another order
    task automatic test_fill_and_drain(int rounds);
        logic [KEY_IN_W-1:0] order [NKEYS];
        logic [KEY_IN_W-1:0] swap_key;
        int                  j;
        for (int r = 0; r < rounds; r++) begin
            send_event(MODE_RELEASE_ALL, KEY_IN_W'($urandom_range(0, 127)));
            for (int i = 0; i < NKEYS; i++)
                order[i] = i[KEY_IN_W-1:0];
            for (int i = 0; i < NKEYS; i++) begin
                j        = $urandom_range(i, NKEYS - 1);
                swap_key = order[i];
                order[i] = order[j];
                order[j] = swap_key;
                send_event(MODE_PRESS, order[i]);
            end
            // list full
            send_event(MODE_PRESS, KEY_IN_W'($urandom_range(0, NKEYS - 1)));
            for (int i = 0; i < NKEYS; i++) begin
                j        = $urandom_range(i, NKEYS - 1);
                swap_key = order[i];
                order[i] = order[j];
                order[j] = swap_key;
                send_event(MODE_RELEASE, order[i]);
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_stack_word want;
        if (i_rst_n && o_valid) begin
            if (expected_words.size() == 0) begin
                report_mismatch("result word with nothing pending", o_top_key, 0);
            end else begin
                want = expected_words.pop_front();
                if (o_top_key !== want.top_key)
                    report_mismatch("top_key", o_top_key, want.top_key);
                if (o_key_held !== want.key_held)
                    report_mismatch("key_held", o_key_held, want.key_held);
                if (o_held_count !== want.held_count)
                    report_mismatch("held_count", o_held_count, want.held_count);
                results_checked++;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no word moved for %0d cycles", IDLE_LIMIT);
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        start    <= 1'b0;
        mode_drv <= MODE_PRESS;
        key_drv  <= '0;
        i_rst_n  <= 1'b0;
        for (int i = 0; i < NKEYS; i++) begin
            stack_keys[i] = '0;
            stack_pos[i]  = '0;
        end
        stack_depth = 0;
        peak_depth  = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_events();
        test_press_release_order();
        test_solo_and_release_all();
        test_random_play(940);
        test_fill_and_drain(3);
        wait_drained();

        if (expected_words.size() != 0)
            report_mismatch("result words never seen", 0, expected_words.size());
        $display("summary: %0d key events (directed, random play, full-stack sweeps), %0d checked",
                 events_sent, results_checked);
        $display("summary: deepest stack %0d of %0d keys, %0d mismatches",
                 peak_depth, NKEYS, mismatches);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
